/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on aclk, idle while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFXC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFXC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sfxc_pkg.sv */
// ---------------------------------------------------------------------------
// sfxc_pkg
// Shared constants and types for the serial frame XOR checker.
// ---------------------------------------------------------------------------
package sfxc_pkg;

    localparam logic [7:0] HEADER_RESET = 8'h41;   // 'A'
    localparam logic [7:0] ASCII_ZERO   = 8'h30;   // '0'

    // One closed frame as seen by the output stage.
    typedef struct packed {
        logic       frame_ok;
        logic [7:0] port_number;
        logic [7:0] device_number;
        logic [7:0] device_type;
    } sfxc_result_t;

endpackage

/* hdl/sfxc_parser.sv */
// ---------------------------------------------------------------------------
// sfxc_parser
// Frame state machine: header hunt, length, payload XOR/capture, checksum.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfxc_parser
    import sfxc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,          // one word consumed this cycle
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   header_byte,
    output logic         res_valid,     // current word closes a frame
    output sfxc_result_t res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg,   len_next;
    logic [7:0] cnt_reg,   cnt_next;
    logic [7:0] xor_reg,   xor_next;
    logic [7:0] type_reg,  type_next;
    logic [7:0] num_reg,   num_next;
    logic [7:0] port_reg,  port_next;
    logic [7:0] cnt_inc;

    assign cnt_inc = cnt_reg + 8'd1;

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        type_next  = type_reg;
        num_next   = num_reg;
        port_next  = port_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == header_byte) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                len_next   = rx_byte - ASCII_ZERO;
                cnt_next   = '0;
                xor_next   = '0;
                type_next  = '0;
                num_next   = '0;
                port_next  = '0;
                phase_next = (len_next == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                xor_next = xor_reg ^ rx_byte;
                case (cnt_reg)
                    8'd0:    type_next = rx_byte;
                    8'd1:    num_next  = rx_byte;
                    8'd2:    port_next = rx_byte;
                    default: ;
                endcase
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg) begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM: begin
                phase_next = PH_IDLE;
                len_next   = '0;
                cnt_next   = '0;
                xor_next   = '0;
                type_next  = '0;
                num_next   = '0;
                port_next  = '0;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            cnt_reg   <= '0;
            xor_reg   <= '0;
            type_reg  <= '0;
            num_reg   <= '0;
            port_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
            type_reg  <= type_next;
            num_reg   <= num_next;
            port_reg  <= port_next;
        end
    end

    assign res_valid         = (phase_reg == PH_SUM);
    assign res.frame_ok      = (rx_byte == xor_reg);
    assign res.device_type   = type_reg;
    assign res.device_number = num_reg;
    assign res.port_number   = port_reg;

    `SFXC_ASSERT_IMP(a_data_len_nonzero, phase_reg == PH_DATA, len_reg != 8'd0,
        "payload phase with zero length")
    `SFXC_ASSERT_IMP(a_data_cnt_below_len, phase_reg == PH_DATA, cnt_reg < len_reg,
        "payload count ran past frame length")
    `SFXC_ASSERT_IMP(a_idle_clean, phase_reg == PH_IDLE,
        (cnt_reg == 8'd0) && (xor_reg == 8'd0) && (type_reg == 8'd0),
        "frame state not cleared while hunting for header")

endmodule

/* hdl/serial_frame_xor_checker.sv */
// ---------------------------------------------------------------------------
// serial_frame_xor_checker
// Parses header/length/payload/checksum frames from a byte stream and emits
// one word per frame: checksum match flag plus the first three payload bytes.
// ---------------------------------------------------------------------------
//
//  Channel    Dir  Word contents
//  s_axis     in   tdata[7:0] = rx_byte
//  m_axis     out  tuser[0] = frame_ok; tdata = device_type, device_number,
//                  port_number (low to high)
//  cfg        in   cfg_wdata[7:0] = header_byte, written when cfg_we is high
//
//  One input word per cycle while s_axis_tready is high; a word that closes a
//  frame lands in the output register and shows in the cycle after it is
//  accepted. The parser update (compare, XOR, count) is combinational.
//  s_axis_tready drops only while a finished word sits unaccepted at m_axis.
//  aresetn is synchronous, active low: parser goes back to header hunt and
//  header_byte returns to 'A'.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_frame_xor_checker
    import sfxc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [7:0] device_type, [15:8] device_number,
                                         // [23:16] port_number
    output logic        m_axis_tuser,    // [0] frame_ok

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata        // header_byte
);

    logic         out_load;
    logic [7:0]   header_reg;
    logic         in_accept;
    logic         res_valid;
    sfxc_result_t res;
    sfxc_result_t out_reg;
    logic         out_valid_reg, out_valid_next;

    // header byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
        end else if (cfg_we) begin
            header_reg <= cfg_wdata;
        end
    end

    // Input may flow whenever the output slot is free or being drained.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sfxc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (in_accept),
        .rx_byte     (s_axis_tdata),
        .header_byte (header_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result slot: load on a closing word, clear when taken
    always_comb begin
        out_load = in_accept && res_valid;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.frame_ok;
    assign m_axis_tdata  = {out_reg.port_number, out_reg.device_number, out_reg.device_type};

    `SFXC_ASSERT_NXT(a_close_gives_word, in_accept && res_valid, m_axis_tvalid,
        "closed frame did not reach the output register")
    `SFXC_ASSERT_IMP(a_no_overwrite, m_axis_tvalid && !m_axis_tready,
        !(in_accept && res_valid), "pending result overwritten")
    `SFXC_ASSERT_NXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "output word dropped while stalled")

endmodule
